// ===== sv/rtcc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtcc_pkg - shared types and constants for the CMOS RTC time field codec
// Payload structs for each pipeline stage, range limits and BCD helpers.
// ----------------------------------------------------------------------------
package rtcc_pkg;

    // Command codes
    localparam logic Cmd_Encode = 1'b0;
    localparam logic Cmd_Decode = 1'b1;

    // Register indexes (byte address bit 2)
    localparam logic Reg_Binary_Mode  = 1'b0;
    localparam logic Reg_Hour_24_Mode = 1'b1;

    // Register reset values
    localparam logic Binary_Mode_Rst  = 1'b0;
    localparam logic Hour_24_Mode_Rst = 1'b1;

    // Range limits for encode
    localparam logic [7:0]  Sec_Max   = 8'd59;
    localparam logic [7:0]  Min_Max   = 8'd59;
    localparam logic [7:0]  Hour_Max  = 8'd23;
    localparam logic [7:0]  Day_Max   = 8'd31;
    localparam logic [7:0]  Month_Max = 8'd12;
    localparam logic [15:0] Year_Base = 16'd2000;
    localparam logic [15:0] Year_Last = 16'd2099;

    localparam logic [7:0]  Half_Day  = 8'd12;
    localparam logic [7:0]  Full_Day  = 8'd24;
    localparam int          Pm_Bit    = 7;
    localparam logic [11:0] Year_Base_Out = 12'd2000;

    // Divide by ten as multiply by reciprocal, exact for 0..1028
    localparam logic [15:0] Div10_Mul   = 16'd205;
    localparam int          Div10_Shift = 11;
    localparam logic [7:0]  Ten         = 8'd10;

    typedef struct packed {
        logic        binary_mode;
        logic        hour_24_mode;
    } t_cfg;

    typedef struct packed {
        logic        command;
        logic [7:0]  in_seconds;
        logic [7:0]  in_minutes;
        logic [7:0]  in_hours;
        logic [7:0]  in_day;
        logic [7:0]  in_month;
        logic [15:0] in_year;
    } t_in;

    typedef struct packed {
        logic [7:0]  out_seconds;
        logic [7:0]  out_minutes;
        logic [7:0]  out_hours;
        logic [7:0]  out_day;
        logic [7:0]  out_month;
        logic [11:0] out_year;
        logic        status;
    } t_out;

    // Intermediate record between stages
    typedef struct packed {
        logic        command;
        logic        bad;
        logic        pm;
        logic [7:0]  sec;
        logic [7:0]  min;
        logic [7:0]  hour;
        logic [7:0]  day;
        logic [7:0]  mon;
        logic [7:0]  year;
    } t_rec;

    // Binary to packed BCD, value below 100
    function automatic logic [7:0] to_bcd(input logic [7:0] v);
        logic [15:0] prod;
        logic [3:0]  tens;
        logic [7:0]  ones;
        prod = {8'd0, v} * Div10_Mul;
        tens = prod[Div10_Shift +: 4];
        ones = v - ({4'd0, tens} * Ten);
        return {tens, ones[3:0]};
    endfunction

    // Packed BCD to binary, bad digits weighted as they stand
    function automatic logic [7:0] bcd_to_bin(input logic [7:0] v);
        return ({4'd0, v[7:4]} * Ten) + {4'd0, v[3:0]};
    endfunction

endpackage

// ===== sv/rtcc_prep.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtcc_prep - first pipeline stage
// Range check and 12-hour fold for encode, PM bit split for decode.
// ----------------------------------------------------------------------------
module rtcc_prep (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rtcc_pkg::t_cfg    i_cfg,
    input  logic              i_valid,
    input  rtcc_pkg::t_in     i_data,
    input  logic              i_ready_nxt,
    output logic              o_ready,
    output logic              o_valid,
    output rtcc_pkg::t_rec    o_data
);

    logic           r_valid;
    rtcc_pkg::t_rec r_data;
    rtcc_pkg::t_rec n_data;
    logic           enc_pm;
    logic [7:0]     enc_hour;

    assign o_ready = !r_valid || i_ready_nxt;

    always_comb begin
        enc_pm   = i_data.in_hours > (rtcc_pkg::Half_Day - 8'd1);
        enc_hour = i_data.in_hours;
        if (!i_cfg.hour_24_mode) begin
            if (enc_pm) begin
                enc_hour = i_data.in_hours - rtcc_pkg::Half_Day;
            end
            if (enc_hour == 8'd0) begin
                enc_hour = rtcc_pkg::Half_Day;
            end
        end
    end

    always_comb begin
        n_data         = '0;
        n_data.command = i_data.command;
        n_data.sec     = i_data.in_seconds;
        n_data.min     = i_data.in_minutes;
        n_data.day     = i_data.in_day;
        n_data.mon     = i_data.in_month;
        if (i_data.command == rtcc_pkg::Cmd_Encode) begin
            n_data.bad  = (i_data.in_seconds > rtcc_pkg::Sec_Max)
                       || (i_data.in_minutes > rtcc_pkg::Min_Max)
                       || (i_data.in_hours   > rtcc_pkg::Hour_Max)
                       || (i_data.in_day     > rtcc_pkg::Day_Max)
                       || (i_data.in_month   > rtcc_pkg::Month_Max)
                       || (i_data.in_year    < rtcc_pkg::Year_Base)
                       || (i_data.in_year    > rtcc_pkg::Year_Last);
            n_data.pm   = enc_pm;
            n_data.hour = enc_hour;
            n_data.year = 8'(i_data.in_year - rtcc_pkg::Year_Base);
        end else begin
            n_data.bad  = 1'b0;
            n_data.pm   = i_data.in_hours[rtcc_pkg::Pm_Bit];
            n_data.hour = {1'b0, i_data.in_hours[6:0]};
            n_data.year = i_data.in_year[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== sv/rtcc_conv.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtcc_conv - second pipeline stage
// Per-field BCD conversion in either direction, or pass-through in binary mode.
// ----------------------------------------------------------------------------
module rtcc_conv (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rtcc_pkg::t_cfg    i_cfg,
    input  logic              i_valid,
    input  rtcc_pkg::t_rec    i_data,
    input  logic              i_ready_nxt,
    output logic              o_ready,
    output logic              o_valid,
    output rtcc_pkg::t_rec    o_data
);

    logic           r_valid;
    rtcc_pkg::t_rec r_data;
    rtcc_pkg::t_rec n_data;

    function automatic logic [7:0] conv(input logic [7:0] v, input logic cmd,
                                        input logic bin);
        logic [7:0] res;
        if (bin) begin
            res = v;
        end else if (cmd == rtcc_pkg::Cmd_Encode) begin
            res = rtcc_pkg::to_bcd(v);
        end else begin
            res = rtcc_pkg::bcd_to_bin(v);
        end
        return res;
    endfunction

    assign o_ready = !r_valid || i_ready_nxt;

    always_comb begin
        n_data      = i_data;
        n_data.sec  = conv(i_data.sec,  i_data.command, i_cfg.binary_mode);
        n_data.min  = conv(i_data.min,  i_data.command, i_cfg.binary_mode);
        n_data.hour = conv(i_data.hour, i_data.command, i_cfg.binary_mode);
        n_data.day  = conv(i_data.day,  i_data.command, i_cfg.binary_mode);
        n_data.mon  = conv(i_data.mon,  i_data.command, i_cfg.binary_mode);
        n_data.year = conv(i_data.year, i_data.command, i_cfg.binary_mode);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== sv/rtcc_fix.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtcc_fix - third pipeline stage and output register
// PM flag insertion or noon/midnight fix, year offset, error blanking.
// ----------------------------------------------------------------------------
module rtcc_fix (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rtcc_pkg::t_cfg    i_cfg,
    input  logic              i_valid,
    input  rtcc_pkg::t_rec    i_data,
    input  logic              i_stall,
    output logic              o_ready,
    output logic              o_valid,
    output rtcc_pkg::t_out    o_data
);

    logic           r_valid;
    rtcc_pkg::t_out r_data;
    rtcc_pkg::t_out n_data;
    logic [7:0]     dec_hour;

    assign o_ready = !r_valid || !i_stall;

    always_comb begin
        dec_hour = i_data.hour;
        if (!i_cfg.hour_24_mode) begin
            if (i_data.pm) begin
                dec_hour = i_data.hour + rtcc_pkg::Half_Day;
            end
            if (dec_hour == rtcc_pkg::Full_Day) begin
                dec_hour = rtcc_pkg::Half_Day;
            end else if (dec_hour == rtcc_pkg::Half_Day) begin
                dec_hour = 8'd0;
            end
        end
    end

    always_comb begin
        n_data             = '0;
        n_data.out_seconds = i_data.sec;
        n_data.out_minutes = i_data.min;
        n_data.out_day     = i_data.day;
        n_data.out_month   = i_data.mon;
        if (i_data.command == rtcc_pkg::Cmd_Encode) begin
            n_data.out_hours = i_data.hour;
            if (i_data.pm && !i_cfg.hour_24_mode) begin
                n_data.out_hours[rtcc_pkg::Pm_Bit] = 1'b1;
            end
            n_data.out_year = {4'd0, i_data.year};
            if (i_data.bad) begin
                n_data        = '0;
                n_data.status = 1'b1;
            end
        end else begin
            n_data.out_hours = dec_hour;
            n_data.out_year  = {4'd0, i_data.year} + rtcc_pkg::Year_Base_Out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== sv/cmos_rtc_time_field_codec_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmos_rtc_time_field_codec_top - CMOS RTC time record codec
// Converts time records between canonical form and RTC register encoding.
// ----------------------------------------------------------------------------
// A three-stage pipeline (range check, BCD conversion, hour/year fix-up) that
// takes one transaction per cycle unless the output stalls; an accepted
// transaction is registered in the prep, conv and fix stages in turn, and the
// fix register drives the output. A stall on the output holds the pipeline, and
// empty stages still fill behind it. Registers: 0x0 binary_mode, 0x4
// hour_24_mode; change them only while no transaction is in flight.
module cmos_rtc_time_field_codec_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Input channel
    input  logic              i_valid,
    input  rtcc_pkg::t_in     i_data,
    output logic              o_stall,
    // Output channel
    output logic              o_valid,
    output rtcc_pkg::t_out    o_data,
    input  logic              i_stall,
    // Register port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic           r_binary_mode;
    logic           r_hour_24_mode;
    rtcc_pkg::t_cfg cfg;
    logic           wr_en;

    logic           prep_ready;
    logic           prep_valid;
    rtcc_pkg::t_rec prep_data;
    logic           conv_ready;
    logic           conv_valid;
    rtcc_pkg::t_rec conv_data;
    logic           fix_ready;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_binary_mode  <= rtcc_pkg::Binary_Mode_Rst;
            r_hour_24_mode <= rtcc_pkg::Hour_24_Mode_Rst;
        end else if (wr_en) begin
            case (paddr[2])
                rtcc_pkg::Reg_Binary_Mode:  r_binary_mode  <= pwdata[0];
                rtcc_pkg::Reg_Hour_24_Mode: r_hour_24_mode <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            rtcc_pkg::Reg_Binary_Mode:  prdata = {31'd0, r_binary_mode};
            rtcc_pkg::Reg_Hour_24_Mode: prdata = {31'd0, r_hour_24_mode};
            default:                    prdata = '0;
        endcase
    end

    assign cfg.binary_mode  = r_binary_mode;
    assign cfg.hour_24_mode = r_hour_24_mode;

    rtcc_prep u_prep (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_valid     (i_valid),
        .i_data      (i_data),
        .i_ready_nxt (conv_ready),
        .o_ready     (prep_ready),
        .o_valid     (prep_valid),
        .o_data      (prep_data)
    );

    rtcc_conv u_conv (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_valid     (prep_valid),
        .i_data      (prep_data),
        .i_ready_nxt (fix_ready),
        .o_ready     (conv_ready),
        .o_valid     (conv_valid),
        .o_data      (conv_data)
    );

    rtcc_fix u_fix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (conv_valid),
        .i_data  (conv_data),
        .i_stall (i_stall),
        .o_ready (fix_ready),
        .o_valid (o_valid),
        .o_data  (o_data)
    );

    assign o_stall = !prep_ready;

endmodule
